/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* rtl/core/adcps_pkg.sv */
// ----------------------------------------------------------------------------
// adcps_pkg
// Types and codes shared by the ADC poll sequencer and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package adcps_pkg;

  // Event kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Sequencer phases.
  localparam logic [1:0] PH_WRITE  = 2'd0;
  localparam logic [1:0] PH_POLL   = 2'd1;
  localparam logic [1:0] PH_READ   = 2'd2;
  localparam logic [1:0] PH_BUSRST = 2'd3;

  // Bus commands.
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_WRITE_CFG = 3'd1;
  localparam logic [2:0] CMD_READ_CFG  = 3'd2;
  localparam logic [2:0] CMD_READ_CONV = 3'd3;
  localparam logic [2:0] CMD_BUS_RESET = 3'd4;

  // Scaling: voltage = raw * 21 / 8, current = raw * 25 / 32.
  localparam logic [4:0] VOLT_MUL = 5'd21;
  localparam logic [4:0] CURR_MUL = 5'd25;

  typedef struct packed {
    logic        kind;
    logic        acked;
    logic [15:0] read_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        channel;
    logic [15:0] voltage_mv;
    logic [15:0] current_ma;
    logic        sample_valid;
    logic        current_updated;
  } out_t;

endpackage

`default_nettype wire

/* rtl/core/adcps_if.sv */
// ----------------------------------------------------------------------------
// adcps channel interfaces
// Valid/ready channels for the sequencer's events and bus commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface adcps_in_if;
  logic             valid;
  logic             ready;
  adcps_pkg::in_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface adcps_out_if;
  logic             valid;
  logic             ready;
  adcps_pkg::out_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/adc_i2c_poll_sequencer.sv */
// ----------------------------------------------------------------------------
// adc_i2c_poll_sequencer
// Issues the next I2C command for single-shot conversions on a two-channel ADC.
// ----------------------------------------------------------------------------
// Each event (a start request or a finished I2C transfer) yields exactly one
// command transaction carrying the next bus command, the channel for a config
// write and the latest scaled results. The block takes one event per clock
// cycle unless a stalled sink holds it back: the event is
// held in an input register, decided against the sequencer state by a short
// piece of logic (byte swap, small constant multiplies, saturate) and
// stored in the output register. Both registers advance whenever the output
// register is empty or being emptied, so a stalled sink holds at most two
// events in flight. A NACK clears both results and the valid flag and always
// produces a bus reset; the transfer that follows the bus reset restarts the
// sequence at channel 0.
`default_nettype none
`include "assert_macros.svh"

module adc_i2c_poll_sequencer (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  adcps_in_if.sink            in_i,
  adcps_out_if.source         out_o
);

  // Input register.
  logic            s1_valid_q;
  adcps_pkg::in_t  s1_data_q;

  // Output register.
  logic            out_valid_q;
  adcps_pkg::out_t out_q, out_d;

  // Sequencer state.
  logic [1:0]  phase_q, phase_d;
  logic        seq_idx_q, seq_idx_d;
  logic [15:0] volt_q, volt_d;
  logic [15:0] curr_q, curr_d;
  logic        valid_flag_q, valid_flag_d;

  logic        s1_move;
  logic [15:0] word;
  logic [19:0] volt_prod;
  logic [19:0] curr_prod;
  logic [15:0] volt_scaled;
  logic [15:0] curr_scaled;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // The bus delivers the word with its bytes swapped.
  assign word = {s1_data_q.read_data[7:0], s1_data_q.read_data[15:8]};

  // Negative raw values clamp to zero; zero scales to zero on its own.
  assign volt_prod = 20'(word[14:0]) * 20'(adcps_pkg::VOLT_MUL);
  assign curr_prod = 20'(word[14:0]) * 20'(adcps_pkg::CURR_MUL);

  always_comb begin
    if (word[15]) begin
      volt_scaled = '0;
    end else if (volt_prod[19]) begin
      volt_scaled = 16'hFFFF;
    end else begin
      volt_scaled = volt_prod[18:3];
    end
  end

  // The current product never exceeds 16 bits after the shift.
  assign curr_scaled = word[15] ? 16'h0000 : {1'b0, curr_prod[19:5]};

  always_comb begin
    phase_d      = phase_q;
    seq_idx_d    = seq_idx_q;
    volt_d       = volt_q;
    curr_d       = curr_q;
    valid_flag_d = valid_flag_q;
    out_d        = '0;
    out_d.command = adcps_pkg::CMD_WRITE_CFG;

    priority if (s1_data_q.kind == adcps_pkg::KIND_START) begin
      phase_d       = adcps_pkg::PH_WRITE;
      seq_idx_d     = 1'b0;
      out_d.command = adcps_pkg::CMD_WRITE_CFG;
    end else if (!s1_data_q.acked) begin
      volt_d        = '0;
      curr_d        = '0;
      valid_flag_d  = 1'b0;
      phase_d       = adcps_pkg::PH_BUSRST;
      out_d.command = adcps_pkg::CMD_BUS_RESET;
    end else begin
      unique case (phase_q)
        adcps_pkg::PH_WRITE: begin
          phase_d       = adcps_pkg::PH_POLL;
          out_d.command = adcps_pkg::CMD_READ_CFG;
        end
        adcps_pkg::PH_POLL: begin
          // Bit 15 of the config register signals a finished conversion.
          if (word[15]) begin
            phase_d       = adcps_pkg::PH_READ;
            out_d.command = adcps_pkg::CMD_READ_CONV;
          end else begin
            out_d.command = adcps_pkg::CMD_READ_CFG;
          end
        end
        adcps_pkg::PH_READ: begin
          if (!seq_idx_q) begin
            volt_d = volt_scaled;
          end else begin
            curr_d                = curr_scaled;
            out_d.current_updated = 1'b1;
          end
          valid_flag_d  = 1'b1;
          seq_idx_d     = ~seq_idx_q;
          phase_d       = adcps_pkg::PH_WRITE;
          out_d.command = adcps_pkg::CMD_WRITE_CFG;
        end
        default: begin
          phase_d       = adcps_pkg::PH_WRITE;
          seq_idx_d     = 1'b0;
          out_d.command = adcps_pkg::CMD_WRITE_CFG;
        end
      endcase
    end

    out_d.channel      = (out_d.command == adcps_pkg::CMD_WRITE_CFG) ? seq_idx_d : 1'b0;
    out_d.voltage_mv   = volt_d;
    out_d.current_ma   = curr_d;
    out_d.sample_valid = valid_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= adcps_pkg::PH_WRITE;
      seq_idx_q    <= 1'b0;
      volt_q       <= '0;
      curr_q       <= '0;
      valid_flag_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (!out_valid_q || out_o.ready) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_move) begin
        phase_q      <= phase_d;
        seq_idx_q    <= seq_idx_d;
        volt_q       <= volt_d;
        curr_q       <= curr_d;
        valid_flag_q <= valid_flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_data_q <= in_i.data;
    end
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  // A presented transaction always carries a real command.
  `ASSERT_NEVER(a_cmd_not_none, clk_i, rst_ni, out_valid_q && (out_q.command == adcps_pkg::CMD_NONE))

  // The channel field is only used by a config write.
  `ASSERT_NEVER(a_chan_only_write, clk_i, rst_ni, out_valid_q && out_q.channel && (out_q.command != adcps_pkg::CMD_WRITE_CFG))

  // A stored current result always leaves the valid flag set.
  `ASSERT_PROP(a_upd_valid, clk_i, rst_ni, !(out_valid_q && out_q.current_updated) || out_q.sample_valid)

  // A bus reset always comes with cleared results.
  `ASSERT_PROP(a_busrst_clear, clk_i, rst_ni, !(out_valid_q && (out_q.command == adcps_pkg::CMD_BUS_RESET)) || ((out_q.voltage_mv == 16'h0000) && (out_q.current_ma == 16'h0000) && !out_q.sample_valid))

endmodule

`default_nettype wire
